// ===== hw/rtl/srpt_pkg.sv =====
// ----------------------------------------------------------------------------
// SRPT scheduler package
// Field widths, transaction types, status codes and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package srpt_pkg;

    localparam int MAX_JOBS    = 16;
    localparam int SLOT_BITS   = $clog2(MAX_JOBS);
    localparam int ID_BITS     = 16;
    localparam int TIME_BITS   = 32;
    localparam int FINISH_BITS = TIME_BITS + 1;

    localparam logic CMD_ARRIVAL    = 1'b0;
    localparam logic CMD_COMPLETION = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_IDLE_DONE = 2'd2;

    typedef struct packed {
        logic                 command;
        logic [ID_BITS-1:0]   job_id;
        logic [TIME_BITS-1:0] job_length;
        logic [TIME_BITS-1:0] now;
    } srpt_in_t;

    typedef struct packed {
        logic                   done_valid;
        logic [ID_BITS-1:0]     done_id;
        logic                   cancel_pending;
        logic                   schedule_valid;
        logic [FINISH_BITS-1:0] finish_time;
        logic [1:0]             status;
    } srpt_out_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic decide;
        logic rd_run;
        logic charge;
        logic insert;
        logic retire;
        logic scan_issue;
        logic commit;
        logic load_out;
    } srpt_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_completion;
        logic table_full;
        logic running;
        logic scan_more;
        logic scan_done;
    } srpt_stat_t;

endpackage

// ===== hw/rtl/srpt_dp.sv =====
// ----------------------------------------------------------------------------
// SRPT scheduler datapath
// Job table memory, used bits, running-job registers, the sequential
// minimum search and the result registers.
// ----------------------------------------------------------------------------
module srpt_dp
    import srpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  srpt_in_t   req,
    input  srpt_cmd_t  cmd,
    output srpt_stat_t stat,
    output srpt_out_t  rsp
);

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] rem;
    } entry_t;

    entry_t mem [MAX_JOBS];
    entry_t rd_data_reg;
    entry_t wr_data;
    logic [SLOT_BITS-1:0] wr_addr;
    logic                 wr_en;
    logic [SLOT_BITS-1:0] rd_addr;

    srpt_in_t  in_reg;
    srpt_out_t res_reg;
    srpt_out_t out_reg;

    logic [MAX_JOBS-1:0]  used_reg;
    logic [SLOT_BITS-1:0] run_slot_reg;
    logic                 run_valid_reg;
    logic [TIME_BITS-1:0] run_start_reg;

    logic [SLOT_BITS:0]   scan_cnt_reg;
    logic                 cmp_vld_reg;
    logic [SLOT_BITS-1:0] cmp_slot_reg;
    logic                 best_found_reg;
    logic [SLOT_BITS-1:0] best_slot_reg;
    entry_t               best_reg;

    logic [SLOT_BITS-1:0] free_slot;
    logic                 table_full;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] charged_rem;
    logic                 better;

    // Lowest free slot.
    always_comb
    begin
        free_slot = '0;
        for (int i = MAX_JOBS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SLOT_BITS'(i);
            end
        end
    end

    assign table_full = &used_reg;

    // Time since the run started, modulo the time width; remaining saturates at zero.
    assign elapsed     = in_reg.now - run_start_reg;
    assign charged_rem = (rd_data_reg.rem > elapsed) ? (rd_data_reg.rem - elapsed) : '0;

    assign better = !best_found_reg
                 || (rd_data_reg.rem < best_reg.rem)
                 || ((rd_data_reg.rem == best_reg.rem) && (rd_data_reg.id < best_reg.id));

    assign rd_addr = cmd.rd_run ? run_slot_reg : scan_cnt_reg[SLOT_BITS-1:0];

    always_comb
    begin
        wr_en   = cmd.charge || cmd.insert;
        wr_addr = free_slot;
        wr_data = '{id: in_reg.job_id, rem: in_reg.job_length};
        if (cmd.charge)
        begin
            wr_addr = run_slot_reg;
            wr_data = '{id: rd_data_reg.id, rem: charged_rem};
        end
    end

    // Job table storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg  <= req;
            res_reg <= '0;
        end
        if (cmd.decide)
        begin
            if (in_reg.command == CMD_ARRIVAL && table_full)
            begin
                res_reg.status <= STATUS_FULL;
            end
            else if (in_reg.command == CMD_COMPLETION && !run_valid_reg)
            begin
                res_reg.status <= STATUS_IDLE_DONE;
            end
        end
        if (cmd.charge)
        begin
            res_reg.cancel_pending <= 1'b1;
        end
        if (cmd.retire)
        begin
            res_reg.done_valid <= 1'b1;
            res_reg.done_id    <= rd_data_reg.id;
        end
        if (cmd.commit && best_found_reg)
        begin
            res_reg.schedule_valid <= 1'b1;
            res_reg.finish_time    <= {1'b0, in_reg.now} + {1'b0, best_reg.rem};
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
        if (cmp_vld_reg && used_reg[cmp_slot_reg] && better)
        begin
            best_reg      <= rd_data_reg;
            best_slot_reg <= cmp_slot_reg;
        end
    end

    // Control state of the table and the search.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            run_slot_reg   <= '0;
            run_valid_reg  <= 1'b0;
            run_start_reg  <= '0;
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_slot_reg   <= '0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            cmp_vld_reg  <= cmd.scan_issue;
            cmp_slot_reg <= scan_cnt_reg[SLOT_BITS-1:0];
            if (cmd.insert)
            begin
                used_reg[free_slot] <= 1'b1;
            end
            if (cmd.retire)
            begin
                used_reg[run_slot_reg] <= 1'b0;
            end
            if (cmd.insert || cmd.retire)
            begin
                scan_cnt_reg   <= '0;
                best_found_reg <= 1'b0;
            end
            if (cmd.scan_issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (cmp_vld_reg && used_reg[cmp_slot_reg])
            begin
                best_found_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                if (best_found_reg)
                begin
                    run_slot_reg  <= best_slot_reg;
                    run_valid_reg <= 1'b1;
                    run_start_reg <= in_reg.now;
                end
                else
                begin
                    run_slot_reg  <= '0;
                    run_valid_reg <= 1'b0;
                    run_start_reg <= '0;
                end
            end
        end
    end

    assign stat.is_completion = (in_reg.command == CMD_COMPLETION);
    assign stat.table_full    = table_full;
    assign stat.running       = run_valid_reg;
    assign stat.scan_more     = (scan_cnt_reg < (SLOT_BITS+1)'(MAX_JOBS));
    assign stat.scan_done     = !stat.scan_more && !cmp_vld_reg;

    assign rsp = out_reg;

endmodule

// ===== hw/rtl/srpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// SRPT scheduler controller
// Sequences each event through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module srpt_ctrl
    import srpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    input  srpt_stat_t stat,
    output srpt_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_RD_RUN,
        S_CHARGE,
        S_INSERT,
        S_RETIRE,
        S_SCAN,
        S_COMMIT,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (stat.is_completion)
                begin
                    state_next = stat.running ? S_RD_RUN : S_RESULT;
                end
                else if (stat.table_full)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = stat.running ? S_RD_RUN : S_INSERT;
                end
            end
            S_RD_RUN:
            begin
                cmd.rd_run = 1'b1;
                state_next = stat.is_completion ? S_RETIRE : S_CHARGE;
            end
            S_CHARGE:
            begin
                cmd.charge = 1'b1;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_SCAN;
            end
            S_RETIRE:
            begin
                cmd.retire = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_issue = stat.scan_more;
                if (stat.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== hw/rtl/srpt_preemptive_scheduler.sv =====
// ----------------------------------------------------------------------------
// SRPT preemptive scheduler
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   srpt_in_t  (arrival or completion)
// rsp       out        rsp_valid/rsp_stall   srpt_out_t (one per request)
//
// Arrival while running: decide, read and charge the running job, insert,
// minimum search, commit, result. Completion while running: decide, read,
// retire, search, commit, result. Arrival while idle: decide, insert, search,
// commit, result. Dropped arrival or completion while idle: decide, result.
// Reset clears the used bits and the running job; the table itself is not reset.
// A result waiting under rsp_stall does not block acceptance of the next request.
// ----------------------------------------------------------------------------
module srpt_preemptive_scheduler
    import srpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  srpt_in_t  req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output srpt_out_t rsp
);

    srpt_cmd_t  cmd;
    srpt_stat_t stat;

    srpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    srpt_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule
